/* hdl/set_assoc_lru_writeback_cache_top_assert.svh */
// Assertion macros for the cache directory.
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_TOP_ASSERT_SVH

`ifndef SYNTH
// Checked with reset held off.
`define SLWC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("slwc assertion failed");
// Checked at every edge, reset included.
`define SLWC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("slwc assertion failed");
`else
`define SLWC_ASSERT(label, prop)
`define SLWC_ASSERT_ALWAYS(label, prop)
`endif

`endif

/* hdl/slwc_pkg.sv */
package slwc_pkg;

    localparam int NUM_WAYS    = 4;
    localparam int NUM_SETS    = 64;
    localparam int BLOCK_BYTES = 32;
    localparam int ADDR_W      = 32;
    localparam int STAMP_W     = 32;

    function automatic int floor_log2(int v);
        int n;
        n = 0;
        for (int i = 1; i < 31; i++) begin
            if ((v >> i) != 0) begin
                n = i;
            end
        end
        return n;
    endfunction

    localparam int OFF_W     = floor_log2(BLOCK_BYTES);
    localparam int SET_W     = floor_log2(NUM_SETS);
    localparam int SET_IDX_W = (SET_W > 0) ? SET_W : 1;
    localparam int SET_DEPTH = 1 << SET_W;
    localparam int TAG_W     = ADDR_W - OFF_W - SET_W;
    localparam int WAY_IDX_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    // Fixed widths of the result fields
    localparam int OUT_SET_W = 6;
    localparam int OUT_TAG_W = 21;
    localparam int OUT_WAY_W = 2;
    localparam int COST_W    = 8;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_CLEAN = 2'd1,
        OUT_DIRTY = 2'd2
    } t_outcome;

    localparam logic [COST_W-1:0] COST_HIT   = COST_W'(1);
    localparam logic [COST_W-1:0] COST_CLEAN = COST_W'(1 + 100);
    localparam logic [COST_W-1:0] COST_DIRTY = COST_W'(201);

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic               dirty;
        logic [STAMP_W-1:0] last_used;
    } t_line;

    typedef t_line [NUM_WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    function automatic logic [SET_IDX_W-1:0] set_of(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] s;
        s = (addr >> OFF_W) & ((ADDR_W'(1) << SET_W) - ADDR_W'(1));
        return s[SET_IDX_W-1:0];
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] t;
        t = addr >> (OFF_W + SET_W);
        return t[TAG_W-1:0];
    endfunction

endpackage

/* hdl/slwc_ram.sv */
module slwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/set_assoc_lru_writeback_cache_top.sv */
// Cache directory, 4-way set associative, 64 sets, 32-byte lines, LRU replacement,
// write-back and write-allocate. Each access (s_axis, tuser = read/write, tdata =
// byte address) yields one result on m_axis: hit / clean miss / dirty miss, the way
// hit or filled, what that way held before, and the cost (1, 101, 201). One access
// per clock is sustained while m_axis_tready stays high. An access transfers into the
// access stage as the row RAM registers its row, then moves into the result register
// once that is free or taken. Tag, dirty bit and timestamp of a set live in one row
// of a single-port-read RAM with a registered read; a write to the set just read is
// forwarded. Valid bits are flip-flops cleared by reset, so no clearing pass is needed.
// The access counter doubles as the LRU timestamp and wraps at 2^32.
module set_assoc_lru_writeback_cache_top
    import slwc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // address[31:0]
    input  logic [0:0]   s_axis_tuser,  // kind[0]: 0 read, 1 write

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // outcome[1:0], seq_number[33:2], set_index[39:34], tag_value[60:40],
    // way[62:61], old_valid[63], old_tag[84:64], old_dirty[85],
    // old_last_used[117:86], cost[125:118], zero[127:126]
    output logic [127:0] m_axis_tdata
);

    `include "set_assoc_lru_writeback_cache_top_assert.svh"

    // access stage
    logic                 r_v;
    logic                 r_kind;
    logic [SET_IDX_W-1:0] r_set;
    logic [TAG_W-1:0]     r_tag;
    logic                 r_fwd;
    t_row                 r_fwd_row;
    logic [STAMP_W-1:0]   r_count;
    logic [NUM_WAYS-1:0]  r_valid [SET_DEPTH];

    // result register
    logic                 r_out_v;
    t_outcome             r_out_outcome;
    logic [STAMP_W-1:0]   r_out_seq;
    logic [OUT_SET_W-1:0] r_out_set;
    logic [OUT_TAG_W-1:0] r_out_tag;
    logic [OUT_WAY_W-1:0] r_out_way;
    logic                 r_out_old_valid;
    logic [OUT_TAG_W-1:0] r_out_old_tag;
    logic                 r_out_old_dirty;
    logic [STAMP_W-1:0]   r_out_old_used;
    logic [COST_W-1:0]    r_out_cost;

    logic                 fire;
    logic                 accept;
    logic [SET_IDX_W-1:0] in_set;
    logic [SET_IDX_W-1:0] rd_set;
    logic [ROW_W-1:0]     ram_q;
    t_row                 row;
    t_row                 n_row;
    logic [NUM_WAYS-1:0]  cur_valid;
    logic [NUM_WAYS-1:0]  hit_vec;
    logic [NUM_WAYS-1:0]  lru_vec;
    logic                 found;
    logic                 empty;
    logic [WAY_IDX_W-1:0] hit_way;
    logic [WAY_IDX_W-1:0] inv_way;
    logic [WAY_IDX_W-1:0] lru_way;
    logic [WAY_IDX_W-1:0] sel;
    t_outcome             n_outcome;
    logic [COST_W-1:0]    n_cost;
    logic                 old_valid;
    t_line                old_line;

    assign fire          = r_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !r_v || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_set        = set_of(s_axis_tdata);
    assign rd_set        = accept ? in_set : r_set;

    slwc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_DEPTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (fire),
        .i_waddr (r_set),
        .i_wdata (n_row),
        .i_raddr (rd_set),
        .o_rdata (ram_q)
    );

    assign row       = r_fwd ? r_fwd_row : t_row'(ram_q);
    assign cur_valid = r_valid[r_set];

    // a way is LRU when strictly older than lower ways and not newer than higher ones
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            hit_vec[w] = cur_valid[w] && (row[w].tag == r_tag);
            lru_vec[w] = 1'b1;
            for (int v = 0; v < NUM_WAYS; v++) begin
                if (v < w && !(row[w].last_used < row[v].last_used)) begin
                    lru_vec[w] = 1'b0;
                end
                if (v > w && (row[v].last_used < row[w].last_used)) begin
                    lru_vec[w] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_IDX_W'(w);
            end
            if (!cur_valid[w]) begin
                inv_way = WAY_IDX_W'(w);
            end
            if (lru_vec[w]) begin
                lru_way = WAY_IDX_W'(w);
            end
        end
    end

    assign found = |hit_vec;
    assign empty = !(&cur_valid);

    always_comb begin
        if (found) begin
            sel = hit_way;
        end else if (empty) begin
            sel = inv_way;
        end else begin
            sel = lru_way;
        end
    end

    assign old_valid = cur_valid[sel];
    assign old_line  = row[sel];

    always_comb begin
        if (found) begin
            n_outcome = OUT_HIT;
            n_cost    = COST_HIT;
        end else if (!empty && old_line.dirty) begin
            n_outcome = OUT_DIRTY;
            n_cost    = COST_DIRTY;
        end else begin
            n_outcome = OUT_CLEAN;
            n_cost    = COST_CLEAN;
        end
    end

    always_comb begin
        n_row = row;
        n_row[sel].last_used = r_count;
        if (found) begin
            n_row[sel].dirty = old_line.dirty | r_kind;
        end else begin
            n_row[sel].tag   = r_tag;
            n_row[sel].dirty = r_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_fwd   <= 1'b0;
            r_count <= '0;
            r_out_v <= 1'b0;
            for (int s = 0; s < SET_DEPTH; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_v <= s_axis_tvalid;
            end
            r_fwd <= accept && fire && (in_set == r_set);
            if (fire) begin
                r_count              <= r_count + STAMP_W'(1);
                r_valid[r_set][sel]  <= 1'b1;
            end
            if (fire) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= s_axis_tuser[0];
            r_set  <= in_set;
            r_tag  <= tag_of(s_axis_tdata);
        end
        r_fwd_row <= n_row;
        if (fire) begin
            r_out_outcome   <= n_outcome;
            r_out_seq       <= r_count;
            r_out_set       <= OUT_SET_W'(r_set);
            r_out_tag       <= OUT_TAG_W'(r_tag);
            r_out_way       <= OUT_WAY_W'(sel);
            r_out_old_valid <= old_valid;
            r_out_old_tag   <= old_valid ? OUT_TAG_W'(old_line.tag) : '0;
            r_out_old_dirty <= old_valid && old_line.dirty;
            r_out_old_used  <= old_valid ? old_line.last_used : '0;
            r_out_cost      <= n_cost;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {2'b00, r_out_cost, r_out_old_used, r_out_old_dirty,
                            r_out_old_tag, r_out_old_valid, r_out_way, r_out_tag,
                            r_out_set, r_out_seq, r_out_outcome};

    // counter advances exactly once per processed access
    `SLWC_ASSERT(a_count_step, fire |=> (r_count == $past(r_count) + STAMP_W'(1)))
    // a processed access always lands in the result register
    `SLWC_ASSERT(a_fire_out, fire |=> r_out_v)
    // forwarded row only ever serves a pending access
    `SLWC_ASSERT_ALWAYS(a_fwd_live, (i_rst_n && r_fwd) |-> r_v)
    // a hit is charged the hit cost
    `SLWC_ASSERT(a_hit_cost, (r_out_v && r_out_outcome == OUT_HIT) |-> (r_out_cost == COST_HIT))

endmodule
